// ===== design/evp_pkg.sv =====
// Shared types and constants for the EV control pilot state and PWM unit.
// Depends on nothing; imported by evp_classify and ev_pilot_state_and_pwm_unit.
package evp_pkg;

    // Field widths.
    localparam int ADC_W  = 12;
    localparam int VOLT_W = 16;
    localparam int STATE_W = 3;
    localparam int DUTY_W = 7;
    localparam int CFG_IDX_W = 2;

    // Converter and supply figures.
    localparam int ADC_FULL_SCALE = 4095;
    localparam int SUPPLY_MV      = 3300;

    // The scaling reading * SUPPLY_MV / ADC_FULL_SCALE is done as one multiply by a
    // rounded-up reciprocal. The shift is chosen so that the error over the whole
    // reading range stays below one part in the full scale, which makes the floor exact.
    localparam int FS_W        = $clog2(ADC_FULL_SCALE + 1);
    localparam int SCALE_SHIFT = ADC_W + FS_W + 1;
    localparam longint unsigned SCALE_MUL =
        ((longint'(SUPPLY_MV) << SCALE_SHIFT) + longint'(ADC_FULL_SCALE) - 1)
        / longint'(ADC_FULL_SCALE);
    localparam int MUL_W  = $clog2(SCALE_MUL + 1);
    localparam int PROD_W = ADC_W + MUL_W;
    localparam longint unsigned VOLT_MAX = (longint'(1) << VOLT_W) - 1;

    // Vehicle state codes.
    localparam logic [STATE_W-1:0] ST_NOT_CONNECTED = 3'd0;
    localparam logic [STATE_W-1:0] ST_CONNECTED     = 3'd1;
    localparam logic [STATE_W-1:0] ST_CHARGING      = 3'd2;
    localparam logic [STATE_W-1:0] ST_VENT          = 3'd3;
    localparam logic [STATE_W-1:0] ST_ERROR         = 3'd4;

    // Duty figures in percent.
    localparam logic [DUTY_W-1:0] DUTY_NOT_CONNECTED = 7'd90;
    localparam logic [DUTY_W-1:0] DUTY_CONNECTED     = 7'd70;
    localparam logic [DUTY_W-1:0] DUTY_CHARGING      = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_VENT          = 7'd30;
    localparam logic [DUTY_W-1:0] DUTY_ERROR         = 7'd10;
    localparam logic [DUTY_W-1:0] DUTY_INIT          = 7'd100;
    localparam logic [DUTY_W-1:0] PWM_PERIOD         = 7'd100;

    // Operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THR_NOT_CONNECTED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_CONNECTED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_CHARGING      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_VENT          = 2'd3;

    typedef struct packed {
        logic             operation;
        logic [ADC_W-1:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] ev_state_out;
        logic               pilot_level;
        logic [VOLT_W-1:0]  scaled_voltage;
    } out_item_t;

    typedef struct packed {
        logic [VOLT_W-1:0] not_connected;
        logic [VOLT_W-1:0] connected;
        logic [VOLT_W-1:0] charging;
        logic [VOLT_W-1:0] vent;
    } thr_t;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [DUTY_W-1:0]  duty;
        logic [VOLT_W-1:0]  voltage;
    } class_t;

endpackage

// ===== design/evp_classify.sv =====
// Scales one converter reading to millivolts and classifies it against the thresholds.
// Depends on evp_pkg.
module evp_classify (
    input  logic [evp_pkg::ADC_W-1:0] adc_sample,
    input  evp_pkg::thr_t             thr,
    output evp_pkg::class_t           result
);
    import evp_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [VOLT_W-1:0] volt;

    always_comb begin
        prod = PROD_W'(adc_sample) * PROD_W'(SCALE_MUL);
        quot = prod >> SCALE_SHIFT;
        // Saturate when the supply to full-scale ratio would overflow the field.
        if (quot > PROD_W'(VOLT_MAX)) begin
            volt = '1;
        end else begin
            volt = quot[VOLT_W-1:0];
        end

        result.voltage = volt;
        if (volt >= thr.not_connected) begin
            result.state = ST_NOT_CONNECTED;
            result.duty  = DUTY_NOT_CONNECTED;
        end else if (volt >= thr.connected) begin
            result.state = ST_CONNECTED;
            result.duty  = DUTY_CONNECTED;
        end else if (volt >= thr.charging) begin
            result.state = ST_CHARGING;
            result.duty  = DUTY_CHARGING;
        end else if (volt >= thr.vent) begin
            result.state = ST_VENT;
            result.duty  = DUTY_VENT;
        end else begin
            result.state = ST_ERROR;
            result.duty  = DUTY_ERROR;
        end
    end

endmodule

// ===== design/ev_pilot_state_and_pwm_unit.sv =====
// An accepted input transaction passes through the input register and then the result register to m_data.
// Throughput: one transaction per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (aresetn low, synchronous): state not connected, duty 100, counter 0,
// pilot high, last voltage 0, thresholds 2800/2300/1800/1300 mV, both stages empty.
// Depends on evp_pkg and evp_classify.
module ev_pilot_state_and_pwm_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  evp_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output evp_pkg::out_item_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [evp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [evp_pkg::VOLT_W-1:0]    cfg_wdata
);
    import evp_pkg::*;

    thr_t               thr_reg;
    in_item_t           in_item_reg;
    logic               in_valid_reg;
    out_item_t          out_item_reg;
    logic               out_valid_reg;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [DUTY_W-1:0]  count_reg, count_next;
    logic               pin_reg, pin_next;
    logic [VOLT_W-1:0]  volt_reg, volt_next;

    class_t             cls;
    logic               advance;
    logic               active;

    evp_classify u_classify (
        .adc_sample (in_item_reg.adc_sample),
        .thr        (thr_reg),
        .result     (cls)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;
    assign active  = (state_reg == ST_CONNECTED) || (state_reg == ST_CHARGING)
                  || (state_reg == ST_VENT);

    always_comb begin
        state_next = state_reg;
        duty_next  = duty_reg;
        count_next = count_reg;
        pin_next   = pin_reg;
        volt_next  = volt_reg;
        if (in_item_reg.operation == OP_SAMPLE) begin
            state_next = cls.state;
            duty_next  = cls.duty;
            volt_next  = cls.voltage;
        end else if (active) begin
            // The tick after the counter passes the period clears it and leaves the pin.
            if (count_reg <= PWM_PERIOD) begin
                pin_next   = (count_reg <= duty_reg);
                count_next = count_reg + 1'b1;
            end else begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.not_connected <= 16'd2800;
            thr_reg.connected     <= 16'd2300;
            thr_reg.charging      <= 16'd1800;
            thr_reg.vent          <= 16'd1300;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_THR_NOT_CONNECTED: thr_reg.not_connected <= cfg_wdata;
                REG_THR_CONNECTED:     thr_reg.connected     <= cfg_wdata;
                REG_THR_CHARGING:      thr_reg.charging      <= cfg_wdata;
                REG_THR_VENT:          thr_reg.vent          <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_NOT_CONNECTED;
            duty_reg      <= DUTY_INIT;
            count_reg     <= '0;
            pin_reg       <= 1'b1;
            volt_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                duty_reg      <= duty_next;
                count_reg     <= count_next;
                pin_reg       <= pin_next;
                volt_reg      <= volt_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg.ev_state_out   <= state_next;
            out_item_reg.pilot_level    <= pin_next;
            out_item_reg.scaled_voltage <= volt_next;
        end
    end

    // The counter never runs beyond one past the period.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PWM_PERIOD + 1'b1)
        else $error("PWM counter out of range");

    // The duty only ever holds one of the defined figures.
    a_duty_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (duty_reg == DUTY_INIT) || (duty_reg == DUTY_NOT_CONNECTED)
        || (duty_reg == DUTY_CONNECTED) || (duty_reg == DUTY_CHARGING)
        || (duty_reg == DUTY_VENT) || (duty_reg == DUTY_ERROR))
        else $error("Illegal duty value");

    // A tick outside the active states changes neither the counter nor the pin.
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_item_reg.operation == OP_TICK) && !active
        |=> $stable(count_reg) && $stable(pin_reg))
        else $error("Tick changed PWM state while inactive");

    // Every item moved out of the input register produces a result.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("Result missing after transaction");

endmodule
